>>> sv/tkl_pkg.sv
// shared constants, types and the type k voltage table for the linearizer
package tkl_pkg;

    localparam int NEG_ENTRIES = 101;
    localparam int POS_ENTRIES = 301;
    localparam int TBL_ENTRIES = NEG_ENTRIES + POS_ENTRIES - 1;
    localparam int ZERO_IDX    = NEG_ENTRIES - 1;
    localparam int IDX_W       = 9;
    localparam int CNT_W       = 10;
    localparam int SRCH_STEPS  = 9;
    localparam int DIV_STEPS   = 10;
    localparam int REM_W       = 27;
    localparam int NSTG        = SRCH_STEPS + DIV_STEPS + 4;

    localparam logic signed [17:0] SAT_LO = 18'(-(NEG_ENTRIES - 1) * 256);
    localparam logic signed [17:0] SAT_HI = 18'((POS_ENTRIES - 1) * 256);

    localparam logic [1:0] CLS_NORM = 2'd0;
    localparam logic [1:0] CLS_ZERO = 2'd1;
    localparam logic [1:0] CLS_LOW  = 2'd2;
    localparam logic [1:0] CLS_HIGH = 2'd3;

    typedef struct packed {
        logic signed [15:0] x;
        logic               neg;
        logic [CNT_W-1:0]   cnt;
    } t_srch;

    typedef struct packed {
        logic [1:0]       cls;
        logic [IDX_W-1:0] ulo;
    } t_tag;

    typedef struct packed {
        t_tag               tag;
        logic signed [16:0] d;
        logic signed [16:0] diff;
    } t_brk;

    typedef struct packed {
        t_tag                tag;
        logic [REM_W-1:0]    rem;
        logic [16:0]         dv;
        logic [DIV_STEPS-1:0] q;
    } t_div;

    // negative table -100..0 C followed by the positive table 1..300 C
    localparam logic signed [15:0] TK_UV [0:TBL_ENTRIES-1] = '{
        -3554, -3523, -3492, -3462, -3431, -3400, -3368, -3337, -3306, -3274,
        -3243, -3211, -3179, -3147, -3115, -3083, -3050, -3018, -2986, -2953,
        -2920, -2887, -2854, -2821, -2788, -2755, -2721, -2688, -2654, -2620,
        -2587, -2553, -2519, -2485, -2450, -2416, -2382, -2347, -2312, -2278,
        -2243, -2208, -2173, -2138, -2103, -2067, -2032, -1996, -1961, -1925,
        -1889, -1854, -1818, -1782, -1745, -1709, -1673, -1637, -1600, -1564,
        -1527, -1490, -1453, -1417, -1380, -1343, -1305, -1268, -1231, -1194,
        -1156, -1119, -1081, -1043, -1006, -968, -930, -892, -854, -816,
        -778, -739, -701, -663, -624, -586, -547, -508, -470, -431,
        -392, -353, -314, -275, -236, -197, -157, -118, -79, -39, 0,
        39, 79, 119, 158, 198, 238, 277, 317, 357,
        397, 437, 477, 517, 557, 597, 637, 677, 718, 758,
        798, 838, 879, 919, 960, 1000, 1041, 1081, 1122, 1163,
        1203, 1244, 1285, 1326, 1366, 1407, 1448, 1489, 1530, 1571,
        1612, 1653, 1694, 1735, 1776, 1817, 1858, 1899, 1941, 1982,
        2023, 2064, 2106, 2147, 2188, 2230, 2271, 2312, 2354, 2395,
        2436, 2478, 2519, 2561, 2602, 2644, 2685, 2727, 2768, 2810,
        2851, 2893, 2934, 2976, 3017, 3059, 3100, 3142, 3184, 3225,
        3267, 3308, 3350, 3391, 3433, 3474, 3516, 3557, 3599, 3640,
        3682, 3723, 3765, 3806, 3848, 3889, 3931, 3972, 4013, 4055,
        4096, 4138, 4179, 4220, 4262, 4303, 4344, 4385, 4427, 4468,
        4509, 4550, 4591, 4633, 4674, 4715, 4756, 4797, 4838, 4879,
        4920, 4961, 5002, 5043, 5084, 5124, 5165, 5206, 5247, 5288,
        5328, 5369, 5410, 5450, 5491, 5532, 5572, 5613, 5653, 5694,
        5735, 5775, 5815, 5856, 5896, 5937, 5977, 6017, 6058, 6098,
        6138, 6179, 6219, 6259, 6299, 6339, 6380, 6420, 6460, 6500,
        6540, 6580, 6620, 6660, 6701, 6741, 6781, 6821, 6861, 6901,
        6941, 6981, 7021, 7060, 7100, 7140, 7180, 7220, 7260, 7300,
        7340, 7380, 7420, 7460, 7500, 7540, 7579, 7619, 7659, 7699,
        7739, 7779, 7819, 7859, 7899, 7939, 7979, 8019, 8059, 8099,
        8138, 8178, 8218, 8258, 8298, 8338, 8378, 8418, 8458, 8499,
        8539, 8579, 8619, 8659, 8699, 8739, 8779, 8819, 8860, 8900,
        8940, 8980, 9020, 9061, 9101, 9141, 9181, 9222, 9262, 9302,
        9343, 9383, 9423, 9464, 9504, 9545, 9585, 9626, 9666, 9707,
        9747, 9788, 9828, 9869, 9909, 9950, 9991, 10031, 10072, 10113,
        10153, 10194, 10235, 10276, 10316, 10357, 10398, 10439, 10480, 10520,
        10561, 10602, 10643, 10684, 10725, 10766, 10807, 10848, 10889, 10930,
        10971, 11012, 11053, 11094, 11135, 11176, 11217, 11259, 11300, 11341,
        11382, 11423, 11465, 11506, 11547, 11588, 11630, 11671, 11712, 11753,
        11795, 11836, 11877, 11919, 11960, 12001, 12043, 12084, 12126, 12167, 12209
    };

    function automatic logic signed [15:0] tk_uv(input logic [IDX_W-1:0] idx);
        logic signed [15:0] r;
        r = 16'sd0;
        if (32'(idx) < TBL_ENTRIES) begin
            r = TK_UV[idx];
        end
        return r;
    endfunction

endpackage

>>> sv/thermocouple_table_linearizer_top.sv
// type k thermocouple linearizer: pipelined table search, bracket and divide
// registers in order: input, search, bracket, divider and output stages
// throughput: one beat per cycle; a stalled output holds the whole pipeline
// search is a 9-stage binary search, the fraction a 10-stage restoring divider
// reset (synchronous, active low) clears the stage valid bits only
module thermocouple_table_linearizer_top import tkl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_voltage_uv,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [17:0] o_temp_q8,
    output logic               o_out_of_range
);

    logic [NSTG-1:0]    r_vld;
    t_srch              r_srch [0:SRCH_STEPS];
    t_srch              n_srch [1:SRCH_STEPS];
    t_brk               r_brk, n_brk;
    t_div               r_div [0:DIV_STEPS];
    t_div               n_div [0:DIV_STEPS];
    logic signed [17:0] r_temp, n_temp;
    logic               r_oor, n_oor;
    logic               adv;

    assign adv            = !r_vld[NSTG-1] || i_ready;
    assign o_ready        = adv;
    assign o_valid        = r_vld[NSTG-1];
    assign o_temp_q8      = r_temp;
    assign o_out_of_range = r_oor;

    // binary search: count of entries below x among the first lim entries
    always_comb begin
        logic [CNT_W-1:0] cand;
        logic [CNT_W-1:0] lim;
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] ridx;
        for (int k = 0; k < SRCH_STEPS; k++) begin
            n_srch[k+1] = r_srch[k];
            lim  = r_srch[k].neg ? CNT_W'(NEG_ENTRIES - 1) : CNT_W'(POS_ENTRIES - 1);
            base = r_srch[k].neg ? CNT_W'(0) : CNT_W'(ZERO_IDX);
            cand = r_srch[k].cnt + (CNT_W'(1) << (SRCH_STEPS - 1 - k));
            ridx = base + cand - CNT_W'(1);
            if (cand <= lim) begin
                if (tk_uv(ridx[IDX_W-1:0]) < r_srch[k].x) begin
                    n_srch[k+1].cnt = cand;
                end
            end
        end
    end

    // bracket entries two apart, clamped at the table ends
    always_comb begin
        t_srch              s;
        logic [CNT_W-1:0]   lim;
        logic [CNT_W-1:0]   base;
        logic [CNT_W-1:0]   lo_rel;
        logic [CNT_W-1:0]   ulo;
        logic signed [15:0] tlo;
        logic signed [15:0] thi;
        s      = r_srch[SRCH_STEPS];
        lim    = s.neg ? CNT_W'(NEG_ENTRIES - 1) : CNT_W'(POS_ENTRIES - 1);
        base   = s.neg ? CNT_W'(0) : CNT_W'(ZERO_IDX);
        lo_rel = (s.cnt == '0) ? '0 : s.cnt - CNT_W'(1);
        if (lo_rel > lim - CNT_W'(2)) begin
            lo_rel = lim - CNT_W'(2);
        end
        ulo = base + lo_rel;
        tlo = tk_uv(ulo[IDX_W-1:0]);
        thi = tk_uv(ulo[IDX_W-1:0] + IDX_W'(2));
        n_brk.tag.ulo = ulo[IDX_W-1:0];
        n_brk.d       = 17'(thi) - 17'(tlo);
        n_brk.diff    = 17'(s.x) - 17'(tlo);
        if (s.x == 16'sd0) begin
            n_brk.tag.cls = CLS_ZERO;
        end else if (s.x < TK_UV[0]) begin
            n_brk.tag.cls = CLS_LOW;
        end else if (s.x > TK_UV[TBL_ENTRIES-1]) begin
            n_brk.tag.cls = CLS_HIGH;
        end else begin
            n_brk.tag.cls = CLS_NORM;
        end
    end

    // numerator with half divisor for round to nearest, then one bit a stage
    always_comb begin
        logic             ok;
        logic [REM_W-1:0] sub;
        ok             = (r_brk.diff > 17'sd0) && (r_brk.d > 17'sd0);
        n_div[0].tag   = r_brk.tag;
        n_div[0].q     = '0;
        n_div[0].dv    = ok ? r_brk.d : 17'd1;
        n_div[0].rem   = ok ? ((REM_W'(r_brk.diff) << 9) + REM_W'(r_brk.d[16:1])) : '0;
        for (int j = 0; j < DIV_STEPS; j++) begin
            n_div[j+1] = r_div[j];
            sub = REM_W'(r_div[j].dv) << (DIV_STEPS - 1 - j);
            if (r_div[j].rem >= sub) begin
                n_div[j+1].rem = r_div[j].rem - sub;
                n_div[j+1].q[DIV_STEPS-1-j] = 1'b1;
            end
        end
    end

    always_comb begin
        t_div               f;
        logic signed [10:0] ulo_s;
        logic signed [17:0] base_t;
        f      = r_div[DIV_STEPS];
        ulo_s  = $signed({2'b00, f.tag.ulo}) - 11'sd100;
        base_t = {ulo_s[9:0], 8'd0};
        n_oor  = 1'b0;
        case (f.tag.cls)
            CLS_ZERO: n_temp = 18'sd0;
            CLS_LOW: begin
                n_temp = SAT_LO;
                n_oor  = 1'b1;
            end
            CLS_HIGH: begin
                n_temp = SAT_HI;
                n_oor  = 1'b1;
            end
            default: n_temp = base_t + $signed({8'd0, f.q});
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_srch[0].x   <= i_voltage_uv;
            r_srch[0].neg <= i_voltage_uv[15];
            r_srch[0].cnt <= '0;
            for (int k = 1; k <= SRCH_STEPS; k++) begin
                r_srch[k] <= n_srch[k];
            end
            r_brk <= n_brk;
            for (int j = 0; j <= DIV_STEPS; j++) begin
                r_div[j] <= n_div[j];
            end
            r_temp <= n_temp;
            r_oor  <= n_oor;
        end
    end

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> (o_temp_q8 == SAT_LO) || (o_temp_q8 == SAT_HI))
        else $error("saturated result has wrong value");

    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_of_range |-> (o_temp_q8 >= SAT_LO) && (o_temp_q8 <= SAT_HI))
        else $error("result outside table span");

    a_frac_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-2] && (r_div[DIV_STEPS].tag.cls == CLS_NORM)
        |-> r_div[DIV_STEPS].q <= DIV_STEPS'(512))
        else $error("interpolation fraction exceeds two degrees");

    a_search_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SRCH_STEPS] |-> r_srch[SRCH_STEPS].cnt <= CNT_W'(POS_ENTRIES - 1))
        else $error("search count beyond table");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(r_vld))
        else $error("pipeline moved during stall");

endmodule
